@@ rtl/xtl_pkg.sv @@
// ----------------------------------------------------------------------------
// xtl_pkg
// Shared types, codes and lookup functions for the XML tag lexer.
// ----------------------------------------------------------------------------
package xtl_pkg;

    localparam int ENTITY_MAX_LEN = 32;

    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_EOS   = 2'd2;

    localparam logic [2:0] TOK_CHAR  = 3'd0;
    localparam logic [2:0] TOK_EMPTY = 3'd1;
    localparam logic [2:0] TOK_DONE  = 3'd2;
    localparam logic [2:0] TOK_END   = 3'd3;
    localparam logic [2:0] TOK_ERR   = 3'd4;

    localparam logic [1:0] FLD_NAME  = 2'd0;
    localparam logic [1:0] FLD_ANAME = 2'd1;
    localparam logic [1:0] FLD_AVAL  = 2'd2;

    localparam logic [2:0] ERR_NAME = 3'd0;
    localparam logic [2:0] ERR_ATTR = 3'd1;
    localparam logic [2:0] ERR_EQ   = 3'd2;
    localparam logic [2:0] ERR_VAL  = 3'd3;
    localparam logic [2:0] ERR_END  = 3'd4;

    localparam logic [1:0] EK_NONE = 2'd0;
    localparam logic [1:0] EK_NAME = 2'd1;
    localparam logic [1:0] EK_DEC  = 2'd2;
    localparam logic [1:0] EK_HEX  = 2'd3;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_WCN  = 5'd1;
    localparam logic [4:0] S_WN   = 5'd2;
    localparam logic [4:0] S_RN   = 5'd3;
    localparam logic [4:0] S_WAN  = 5'd4;
    localparam logic [4:0] S_RAN  = 5'd5;
    localparam logic [4:0] S_WEQ  = 5'd6;
    localparam logic [4:0] S_WAV  = 5'd7;
    localparam logic [4:0] S_RAV  = 5'd8;
    localparam logic [4:0] S_Q1   = 5'd9;
    localparam logic [4:0] S_Q2   = 5'd10;
    localparam logic [4:0] S_WC1  = 5'd11;
    localparam logic [4:0] S_WC2  = 5'd12;
    localparam logic [4:0] S_RC   = 5'd13;
    localparam logic [4:0] S_WEC1 = 5'd14;
    localparam logic [4:0] S_WEC2 = 5'd15;
    localparam logic [4:0] S_WEND = 5'd16;
    localparam logic [4:0] S_ERR  = 5'd17;

    typedef struct packed {
        logic [2:0] token;
        logic [1:0] field;
        logic [7:0] char_out;
        logic       restart;
        logic       closing;
        logic       self_closing;
        logic       comment;
        logic [2:0] error_code;
        logic       last;
    } t_res;

    // entity name character at a position, 0 past its end
    function automatic logic [7:0] ent_name_ch(input logic [2:0] idx, input logic [5:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            3'd1: ch = (pos == 6'd0) ? "l" : (pos == 6'd1) ? "t" : 8'h00;
            3'd2: ch = (pos == 6'd0) ? "g" : (pos == 6'd1) ? "t" : 8'h00;
            3'd3: ch = (pos == 6'd0) ? "a" : (pos == 6'd1) ? "m" :
                       (pos == 6'd2) ? "p" : 8'h00;
            3'd4: ch = (pos == 6'd0) ? "q" : (pos == 6'd1) ? "u" :
                       (pos == 6'd2) ? "o" : (pos == 6'd3) ? "t" : 8'h00;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [5:0] ent_len(input logic [2:0] idx);
        logic [5:0] n;
        case (idx)
            3'd1, 3'd2: n = 6'd2;
            3'd3:       n = 6'd3;
            3'd4:       n = 6'd4;
            default:    n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd1:    ch = "<";
            3'd2:    ch = ">";
            3'd3:    ch = "&";
            3'd4:    ch = 8'h22;
            default: ch = "?";
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] field_of(input logic [4:0] st);
        logic [1:0] f;
        case (st)
            S_WAN, S_RAN, S_WEQ:      f = FLD_ANAME;
            S_WAV, S_RAV, S_Q1, S_Q2: f = FLD_AVAL;
            default:                  f = FLD_NAME;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] err_of(input logic [4:0] st);
        logic [2:0] e;
        case (st)
            S_WN, S_WCN, S_RN:        e = ERR_NAME;
            S_WAN, S_RAN:             e = ERR_ATTR;
            S_WEQ:                    e = ERR_EQ;
            S_WAV, S_RAV, S_Q1, S_Q2: e = ERR_VAL;
            default:                  e = ERR_END;
        endcase
        return e;
    endfunction

    function automatic t_res mk_res(input logic [2:0] tok, input logic [1:0] fld,
                                    input logic [7:0] ch, input logic rst,
                                    input logic [2:0] err, input logic cl,
                                    input logic sc, input logic cm);
        t_res r;
        r.token        = tok;
        r.field        = fld;
        r.char_out     = ch;
        r.restart      = rst;
        r.closing      = (tok == TOK_END) ? cl : 1'b0;
        r.self_closing = (tok == TOK_END) ? sc : 1'b0;
        r.comment      = (tok == TOK_END) ? cm : 1'b0;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/xml_tag_lexer.sv @@
// ----------------------------------------------------------------------------
// xml_tag_lexer
// Streaming lexer for the body of one XML tag, one character per transaction.
// ----------------------------------------------------------------------------
// Results are registered into the result queue on the edge that accepts the input.
// Throughput: 1 input per cycle; each input yields 0..2 results, drained at
//   1 per cycle while i_ready is high from a 4-entry result queue, so inputs
//   stall only while the queue holds more than 2 results.
// Reset: synchronous active-low; lexer idle, queue empty.
module xml_tag_lexer
    import xtl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_token,
    output logic [1:0] o_field,
    output logic [7:0] o_char_out,
    output logic       o_restart,
    output logic       o_closing,
    output logic       o_self_closing,
    output logic       o_comment,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    logic [4:0]  r_st, n_st;
    logic        r_cf, n_cf, r_sf, n_sf, r_cmf, n_cmf, r_qt, n_qt;
    logic        r_ea, n_ea, r_ns, n_ns, r_esf, n_esf;
    logic [5:0]  r_el, n_el;
    logic [1:0]  r_ek, n_ek;
    logic [2:0]  r_nm, n_nm;
    logic [30:0] r_nv, n_nv;

    t_res        res [2];
    logic [1:0]  cnt;

    t_res        r_q [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_qc;

    logic        in_fire, out_fire;

    always_comb begin
        logic [7:0]  c, term, dch, edec;
        logic        set, add, is_alnum, done, dig_ok;
        logic [1:0]  fld;
        logic [3:0]  d;
        logic [35:0] v;

        n_st = r_st; n_cf = r_cf; n_sf = r_sf; n_cmf = r_cmf; n_qt = r_qt;
        n_ea = r_ea; n_el = r_el; n_ek = r_ek; n_nm = r_nm; n_nv = r_nv;
        n_ns = r_ns; n_esf = r_esf;
        res[0] = '0; res[1] = '0; cnt = 2'd0;
        c = i_char_in; term = r_qt ? "?" : "/";
        set = 1'b0; add = 1'b0; done = 1'b0; fld = FLD_NAME;
        d = 4'd0; dig_ok = 1'b0; v = '0; dch = 8'h00; edec = "?";
        is_alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9");

        // decoded value of the pending entity
        if (r_ek == EK_NONE) edec = "?";
        else if (r_ek == EK_NAME)
            edec = (r_nm != 3'd0 && r_el == ent_len(r_nm)) ? ent_char(r_nm) : "?";
        else edec = r_nv[7:0];

        if (in_fire) begin
            if (i_opcode == OP_BEGIN) begin
                n_st = S_WCN; n_cf = 1'b0; n_sf = 1'b0; n_cmf = 1'b0; n_qt = 1'b0;
                n_ea = 1'b0; n_el = '0; n_ek = EK_NONE; n_nm = '0; n_nv = '0;
                n_ns = 1'b0; n_esf = 1'b0;
            end else if ((i_opcode == OP_CHAR || i_opcode == OP_EOS) &&
                         r_st != S_IDLE && r_st != S_ERR) begin
                // entity emit, shared by end of stream and entity feed
                dch = 8'h00;
                if (i_opcode == OP_EOS) begin
                    if (r_ea) begin
                        dch = edec; done = 1'b1;
                    end
                end else if (r_ea) begin
                    if (c == ";") begin
                        dch = edec; done = 1'b1;
                    end else if (!(is_alnum || c == "#") ||
                                 r_el >= 6'(ENTITY_MAX_LEN)) begin
                        dch = "?"; done = 1'b1;
                    end else begin
                        if (r_el == 6'd0) begin
                            if (c == "#") n_ek = EK_DEC;
                            else begin
                                n_ek = EK_NAME;
                                n_nm = (c == "l") ? 3'd1 : (c == "g") ? 3'd2 :
                                       (c == "a") ? 3'd3 : (c == "q") ? 3'd4 : 3'd0;
                            end
                        end else if (r_ek == EK_NAME) begin
                            if (!(r_nm != 3'd0 && r_el < ent_len(r_nm) &&
                                  ent_name_ch(r_nm, r_el) == c))
                                n_nm = 3'd0;
                        end else if (r_ek == EK_DEC && r_el == 6'd1 && c == "x") begin
                            n_ek = EK_HEX;
                        end else begin
                            if (c >= "0" && c <= "9") begin
                                d = 4'(c - "0"); dig_ok = 1'b1;
                            end else if (r_ek == EK_HEX && c >= "a" && c <= "f") begin
                                d = 4'(c - "a" + 8'd10); dig_ok = 1'b1;
                            end else if (r_ek == EK_HEX && c >= "A" && c <= "F") begin
                                d = 4'(c - "A" + 8'd10); dig_ok = 1'b1;
                            end
                            if (!r_ns && dig_ok) begin
                                if (r_ek == EK_HEX)
                                    v = {1'b0, r_nv, 4'd0} + 36'(d);
                                else
                                    v = {2'b0, r_nv, 3'd0} + {4'b0, r_nv, 1'b0} + 36'(d);
                                n_nv = (v > 36'h07FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
                            end else begin
                                n_ns = 1'b1;
                            end
                        end
                        n_el = r_el + 6'd1;
                    end
                end
                if (done) begin
                    if (dch == 8'h00) begin
                        if (r_esf) begin
                            res[cnt[0]] = mk_res(TOK_EMPTY, FLD_AVAL, 8'h00, 1'b0, 3'd0,
                                                 n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                        end
                    end else begin
                        res[cnt[0]] = mk_res(TOK_CHAR, FLD_AVAL, dch, r_esf, 3'd0,
                                             n_cf, n_sf, n_cmf);
                        cnt = cnt + 2'd1;
                    end
                    n_ea = 1'b0; n_el = '0; n_ek = EK_NONE; n_nm = '0; n_nv = '0;
                    n_ns = 1'b0; n_esf = 1'b0;
                end

                if (i_opcode == OP_EOS) begin
                    res[cnt[0]] = mk_res(TOK_END, FLD_NAME, 8'h00, 1'b0, 3'd0,
                                         n_cf, n_sf, n_cmf);
                    cnt = cnt + 2'd1;
                    n_st = S_IDLE;
                end else if (!r_ea) begin
                    // tag character
                    if (r_st == S_Q1 || r_st == S_Q2) begin
                        if ((r_st == S_Q1 && c == 8'h22) || (r_st == S_Q2 && c == 8'h27)) begin
                            res[cnt[0]] = mk_res(TOK_DONE, FLD_AVAL, 8'h00, 1'b0, 3'd0,
                                                 n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_WAN;
                        end else if (c == "&") begin
                            n_ea = 1'b1; n_el = '0; n_ek = EK_NONE; n_nm = '0;
                            n_nv = '0; n_ns = 1'b0; n_esf = 1'b0;
                        end else begin
                            res[cnt[0]] = mk_res(TOK_CHAR, FLD_AVAL, c, 1'b0, 3'd0,
                                                 n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                        end
                    end else if (r_st == S_RC && c != "-") begin
                        n_st = r_st;
                    end else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
                        if (r_st == S_RN || r_st == S_RAN || r_st == S_RAV) begin
                            res[cnt[0]] = mk_res(TOK_DONE, field_of(r_st), 8'h00, 1'b0,
                                                 3'd0, n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = (r_st == S_RAN) ? S_WEQ : S_WAN;
                        end
                    end else if (c == ">") begin
                        if (r_st == S_WEC2) begin
                            n_cmf = 1'b1; n_cf = 1'b1;
                            res[cnt[0]] = mk_res(TOK_END, FLD_NAME, 8'h00, 1'b0, 3'd0,
                                                 n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_IDLE;
                        end else if (r_st != S_WEND && r_st != S_WAN && r_st != S_RAV &&
                                     r_st != S_RN) begin
                            res[cnt[0]] = mk_res(TOK_ERR, FLD_NAME, 8'h00, 1'b0,
                                                 err_of(r_st), n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_ERR; n_ea = 1'b0;
                        end else begin
                            if (r_st == S_RN || r_st == S_RAV) begin
                                res[cnt[0]] = mk_res(TOK_DONE, field_of(r_st), 8'h00,
                                                     1'b0, 3'd0, n_cf, n_sf, n_cmf);
                                cnt = cnt + 2'd1;
                            end
                            res[cnt[0]] = mk_res(TOK_END, FLD_NAME, 8'h00, 1'b0, 3'd0,
                                                 n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_IDLE;
                        end
                    end else if (c == term) begin
                        if (r_st == S_WCN) begin
                            n_st = S_WN; n_cf = 1'b1;
                        end else if (r_st != S_WAN && r_st != S_RAV && r_st != S_RN) begin
                            res[cnt[0]] = mk_res(TOK_ERR, FLD_NAME, 8'h00, 1'b0,
                                                 err_of(r_st), n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_ERR; n_ea = 1'b0;
                        end else begin
                            if (r_st == S_RN || r_st == S_RAV) begin
                                res[cnt[0]] = mk_res(TOK_DONE, field_of(r_st), 8'h00,
                                                     1'b0, 3'd0, n_cf, n_sf, n_cmf);
                                cnt = cnt + 2'd1;
                            end
                            n_sf = 1'b1; n_st = S_WEND;
                        end
                    end else if (c == "=") begin
                        if (r_st != S_WEQ && r_st != S_RAN) begin
                            res[cnt[0]] = mk_res(TOK_ERR, FLD_NAME, 8'h00, 1'b0,
                                                 err_of(r_st), n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_ERR; n_ea = 1'b0;
                        end else begin
                            if (r_st == S_RAN) begin
                                res[cnt[0]] = mk_res(TOK_DONE, FLD_ANAME, 8'h00, 1'b0,
                                                     3'd0, n_cf, n_sf, n_cmf);
                                cnt = cnt + 2'd1;
                            end
                            n_st = S_WAV;
                        end
                    end else if (c == 8'h27 || c == 8'h22) begin
                        if (r_st != S_WAV) begin
                            res[cnt[0]] = mk_res(TOK_ERR, FLD_NAME, 8'h00, 1'b0,
                                                 err_of(r_st), n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = S_ERR; n_ea = 1'b0;
                        end else begin
                            res[cnt[0]] = mk_res(TOK_EMPTY, FLD_AVAL, 8'h00, 1'b0, 3'd0,
                                                 n_cf, n_sf, n_cmf);
                            cnt = cnt + 2'd1;
                            n_st = (c == 8'h22) ? S_Q1 : S_Q2;
                        end
                    end else begin
                        fld = field_of(r_st);
                        case (r_st)
                            S_WCN, S_WN: begin
                                set = 1'b1;
                                if (c == "!") n_st = S_WC1;
                                else begin
                                    if (c == "?") n_qt = 1'b1;
                                    n_st = S_RN;
                                end
                            end
                            S_WAN: begin
                                set = 1'b1; n_st = S_RAN;
                            end
                            S_WAV: begin
                                set = 1'b1; n_st = S_RAV;
                            end
                            S_RN, S_RAN, S_RAV: add = 1'b1;
                            S_WC1, S_WC2: begin
                                add = 1'b1;
                                if (c != "-") n_st = S_WN;
                                else n_st = (r_st == S_WC1) ? S_WC2 : S_RC;
                            end
                            S_RC:   if (c == "-") n_st = S_WEC1;
                            S_WEC1: n_st = (c == "-") ? S_WEC2 : S_RC;
                            S_WEC2: if (c != "-") n_st = S_RC;
                            default: begin
                                res[cnt[0]] = mk_res(TOK_ERR, FLD_NAME, 8'h00, 1'b0,
                                                     err_of(r_st), n_cf, n_sf, n_cmf);
                                cnt = cnt + 2'd1;
                                n_st = S_ERR; n_ea = 1'b0;
                            end
                        endcase
                        if (n_st != S_ERR) begin
                            if (c == "&") begin
                                if (n_st != S_RAV) begin
                                    res[cnt[0]] = mk_res(TOK_ERR, FLD_NAME, 8'h00, 1'b0,
                                                         err_of(n_st), n_cf, n_sf, n_cmf);
                                    cnt = cnt + 2'd1;
                                    n_st = S_ERR; n_ea = 1'b0;
                                end else if (set || add) begin
                                    n_ea = 1'b1; n_el = '0; n_ek = EK_NONE; n_nm = '0;
                                    n_nv = '0; n_ns = 1'b0; n_esf = set;
                                end
                            end else if (set || add) begin
                                res[cnt[0]] = mk_res(TOK_CHAR, fld, c, set, 3'd0,
                                                     n_cf, n_sf, n_cmf);
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                end
            end
        end
        if (cnt == 2'd1) res[0].last = 1'b1;
        if (cnt == 2'd2) res[1].last = 1'b1;
    end

    assign o_ready  = (r_qc <= 3'd2);
    assign in_fire  = i_valid && o_ready;
    assign o_valid  = (r_qc != 3'd0);
    assign out_fire = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cf <= 1'b0; r_sf <= 1'b1; r_cmf <= 1'b0; r_qt <= 1'b0;
            r_ea <= 1'b0; r_el <= '0; r_ek <= EK_NONE; r_nm <= '0; r_nv <= '0;
            r_ns <= 1'b0; r_esf <= 1'b0;
            r_wp <= '0; r_rp <= '0; r_qc <= '0;
        end else begin
            r_st <= n_st; r_cf <= n_cf; r_sf <= n_sf; r_cmf <= n_cmf; r_qt <= n_qt;
            r_ea <= n_ea; r_el <= n_el; r_ek <= n_ek; r_nm <= n_nm; r_nv <= n_nv;
            r_ns <= n_ns; r_esf <= n_esf;
            r_wp <= r_wp + cnt;
            r_rp <= r_rp + 2'(out_fire);
            r_qc <= r_qc + 3'(cnt) - 3'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt != 2'd0) r_q[r_wp] <= res[0];
        if (cnt == 2'd2) r_q[r_wp + 2'd1] <= res[1];
    end

    assign o_token        = r_q[r_rp].token;
    assign o_field        = r_q[r_rp].field;
    assign o_char_out     = r_q[r_rp].char_out;
    assign o_restart      = r_q[r_rp].restart;
    assign o_closing      = r_q[r_rp].closing;
    assign o_self_closing = r_q[r_rp].self_closing;
    assign o_comment      = r_q[r_rp].comment;
    assign o_error_code   = r_q[r_rp].error_code;
    assign o_last         = r_q[r_rp].last;

endmodule

@@ rtl/xtl_checker.sv @@
// ----------------------------------------------------------------------------
// xtl_checker
// Port-level checks on the result stream of the XML tag lexer.
// ----------------------------------------------------------------------------
module xtl_checker
    import xtl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_token,
    input logic [2:0] o_error_code,
    input logic       o_closing,
    input logic       o_self_closing,
    input logic       o_comment,
    input logic       o_restart
);

    a_tok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token <= TOK_ERR))
        else $error("token out of range");

    a_err_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token != TOK_ERR) |-> (o_error_code == 3'd0))
        else $error("error code outside error token");

    a_flags_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token != TOK_END) |-> !(o_closing || o_self_closing || o_comment))
        else $error("tag flags outside tag end");

    a_comment_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_comment) |-> o_closing)
        else $error("comment without closing");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_token) && $stable(o_restart)))
        else $error("stalled result changed");

endmodule

bind xml_tag_lexer xtl_checker u_xtl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_token        (o_token),
    .o_error_code   (o_error_code),
    .o_closing      (o_closing),
    .o_self_closing (o_self_closing),
    .o_comment      (o_comment),
    .o_restart      (o_restart)
);

@@ tb/xml_tag_lexer_test.sv @@
// ----------------------------------------------------------------------------
// xml_tag_lexer_test
// Self-checking bench: tag streams go through a queued driver, a predictor
// tracks lexer state per accepted transaction, the monitor compares results.
// ----------------------------------------------------------------------------
module xml_tag_lexer_test;
    import xtl_pkg::*;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } t_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_opcode = OP_EOS;
    logic [7:0] i_char_in = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_token;
    logic [1:0] o_field;
    logic [7:0] o_char_out;
    logic       o_restart, o_closing, o_self_closing, o_comment;
    logic [2:0] o_error_code;
    logic       o_last;

    xml_tag_lexer DUT (.*);

    always #6 i_clk = ~i_clk;

    t_item pending[$];
    t_res  expected_tokens[$];
    int    errors = 0;
    int    send_idle = 0, recv_stall = 0;
    int    quiet_cycles = 0;
    bit    running = 1'b0;

    // lexer model state
    logic [4:0]  lx_state;
    logic        lx_cl, lx_sc, lx_cm, lx_qterm;
    logic        en_act, en_start, en_stop;
    logic [5:0]  en_len;
    logic [1:0]  en_kind;
    logic [2:0]  en_match;
    logic [31:0] en_val;
    t_res        step_out[$];

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void emit(input logic [2:0] tok, input logic [1:0] fld,
                                 input logic [7:0] ch, input logic rs,
                                 input logic [2:0] err);
        t_res r;
        if (step_out.size() >= 2) return;
        r = '0;
        r.token = tok; r.field = fld; r.char_out = ch; r.restart = rs;
        r.error_code = err;
        if (tok == TOK_END) begin
            r.closing = lx_cl; r.self_closing = lx_sc; r.comment = lx_cm;
        end
        step_out.push_back(r);
    endfunction

    function automatic void ent_reset();
        en_act = 0; en_len = 0; en_kind = EK_NONE; en_match = 0;
        en_val = 0; en_stop = 0; en_start = 0;
    endfunction

    function automatic void ent_out(input logic [7:0] ch);
        if (ch == 8'h00) begin
            if (en_start) emit(TOK_EMPTY, FLD_AVAL, 8'h00, 1'b0, 3'd0);
        end else begin
            emit(TOK_CHAR, FLD_AVAL, ch, en_start, 3'd0);
        end
        ent_reset();
    endfunction

    function automatic logic [7:0] ent_value();
        string nm[4] = '{"lt", "gt", "amp", "quot"};
        logic [7:0] cv[4] = '{8'h3C, 8'h3E, 8'h26, 8'h22};
        if (en_kind == EK_NONE) return "?";
        if (en_kind == EK_NAME) begin
            if (en_match >= 1 && en_match <= 4 && en_len == nm[en_match-1].len())
                return cv[en_match-1];
            return "?";
        end
        return en_val[7:0];
    endfunction

    function automatic void ent_char_in(input logic [7:0] c);
        string nm[4] = '{"lt", "gt", "amp", "quot"};
        logic [5:0] p;
        int d, b;
        logic ok;
        logic [63:0] v;
        if (c == ";") begin ent_out(ent_value()); return; end
        if (!((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
              (c >= "0" && c <= "9") || c == "#")) begin
            ent_out("?"); return;
        end
        if (en_len >= ENTITY_MAX_LEN) begin ent_out("?"); return; end
        p = en_len;
        if (p == 0) begin
            if (c == "#") en_kind = EK_DEC;
            else begin
                en_kind = EK_NAME; en_match = 0;
                for (int i = 0; i < 4; i++) if (nm[i][0] == c) en_match = i + 1;
            end
        end else if (en_kind == EK_NAME) begin
            if (en_match >= 1 && en_match <= 4) begin
                if (!(p < nm[en_match-1].len() && nm[en_match-1][p] == c)) en_match = 0;
            end else en_match = 0;
        end else if (en_kind == EK_DEC && p == 1 && c == "x") begin
            en_kind = EK_HEX;
        end else begin
            b = (en_kind == EK_HEX) ? 16 : 10;
            ok = 1; d = 0;
            if (c >= "0" && c <= "9") d = c - "0";
            else if (b == 16 && c >= "a" && c <= "f") d = c - "a" + 10;
            else if (b == 16 && c >= "A" && c <= "F") d = c - "A" + 10;
            else ok = 0;
            if (!en_stop && ok) begin
                v = 64'(en_val) * b + d;
                en_val = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
            end else en_stop = 1;
        end
        en_len = p + 1;
    endfunction

    function automatic void lex_error();
        logic [2:0] e;
        case (lx_state)
            S_WN, S_WCN, S_RN:        e = ERR_NAME;
            S_WAN, S_RAN:             e = ERR_ATTR;
            S_WEQ:                    e = ERR_EQ;
            S_WAV, S_RAV, S_Q1, S_Q2: e = ERR_VAL;
            default:                  e = ERR_END;
        endcase
        emit(TOK_ERR, FLD_NAME, 8'h00, 1'b0, e);
        lx_state = S_ERR;
        en_act = 0;
    endfunction

    function automatic void close_field();
        if (lx_state == S_RN) begin
            emit(TOK_DONE, FLD_NAME, 0, 0, 0); lx_state = S_WAN;
        end else if (lx_state == S_RAN) begin
            emit(TOK_DONE, FLD_ANAME, 0, 0, 0); lx_state = S_WEQ;
        end else if (lx_state inside {S_RAV, S_Q1, S_Q2}) begin
            emit(TOK_DONE, FLD_AVAL, 0, 0, 0); lx_state = S_WAN;
        end
    endfunction

    function automatic void lex_char(input logic [7:0] c);
        logic [4:0] st;
        logic [7:0] term;
        logic [1:0] fld;
        logic set_f, add_f;
        st = lx_state;
        term = lx_qterm ? "?" : "/";
        set_f = 0; add_f = 0;
        if (st == S_Q1 || st == S_Q2) begin
            if ((st == S_Q1 && c == 8'h22) || (st == S_Q2 && c == 8'h27)) close_field();
            else if (c == "&") begin ent_reset(); en_act = 1; en_start = 0; end
            else emit(TOK_CHAR, FLD_AVAL, c, 0, 0);
            return;
        end
        if (st == S_RC && c != "-") return;
        if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
            if (st inside {S_RN, S_RAN, S_RAV}) close_field();
            return;
        end
        if (c == ">") begin
            if (st == S_WEC2) begin lx_cm = 1; lx_cl = 1; end
            else begin
                if (!(st inside {S_WEND, S_WAN, S_RAV, S_RN})) begin lex_error(); return; end
                close_field();
            end
            emit(TOK_END, 0, 0, 0, 0);
            lx_state = S_IDLE;
            return;
        end
        if (c == term) begin
            if (st == S_WCN) begin lx_state = S_WN; lx_cl = 1; return; end
            if (!(st inside {S_WAN, S_RAV, S_RN})) begin lex_error(); return; end
            close_field();
            lx_sc = 1;
            lx_state = S_WEND;
            return;
        end
        if (c == "=") begin
            if (st != S_WEQ && st != S_RAN) begin lex_error(); return; end
            close_field();
            lx_state = S_WAV;
            return;
        end
        if (c == 8'h27 || c == 8'h22) begin
            if (st != S_WAV) begin lex_error(); return; end
            emit(TOK_EMPTY, FLD_AVAL, 0, 0, 0);
            lx_state = (c == 8'h22) ? S_Q1 : S_Q2;
            return;
        end
        if (st inside {S_WAN, S_RAN, S_WEQ}) fld = FLD_ANAME;
        else if (st inside {S_WAV, S_RAV, S_Q1, S_Q2}) fld = FLD_AVAL;
        else fld = FLD_NAME;
        case (st)
            S_WCN, S_WN: begin
                set_f = 1;
                if (c == "!") lx_state = S_WC1;
                else begin
                    if (c == "?") lx_qterm = 1;
                    lx_state = S_RN;
                end
            end
            S_WAN: begin set_f = 1; lx_state = S_RAN; end
            S_WAV: begin set_f = 1; lx_state = S_RAV; end
            S_RN, S_RAN, S_RAV: add_f = 1;
            S_WC1, S_WC2: begin
                add_f = 1;
                if (c != "-") lx_state = S_WN;
                else lx_state = (st == S_WC1) ? S_WC2 : S_RC;
            end
            S_RC: if (c == "-") lx_state = S_WEC1;
            S_WEC1: lx_state = (c == "-") ? S_WEC2 : S_RC;
            S_WEC2: if (c != "-") lx_state = S_RC;
            default: begin lex_error(); return; end
        endcase
        if (c == "&") begin
            if (lx_state != S_RAV) begin lex_error(); return; end
            if (set_f || add_f) begin ent_reset(); en_act = 1; en_start = set_f; end
        end else if (set_f || add_f) begin
            emit(TOK_CHAR, fld, c, set_f, 0);
        end
    endfunction

    function automatic void predict_lexer(input t_item it);
        step_out.delete();
        if (it.op == OP_BEGIN) begin
            lx_state = S_WCN;
            lx_cl = 0; lx_sc = 0; lx_cm = 0; lx_qterm = 0;
            ent_reset();
        end else if (it.op == OP_CHAR) begin
            if (lx_state != S_IDLE && lx_state != S_ERR) begin
                if (en_act) ent_char_in(it.ch);
                else lex_char(it.ch);
            end
        end else if (it.op == OP_EOS) begin
            if (lx_state != S_IDLE && lx_state != S_ERR) begin
                if (en_act) ent_out(ent_value());
                emit(TOK_END, 0, 0, 0, 0);
                lx_state = S_IDLE;
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (running) begin
            if (!(i_valid && !o_ready)) begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_valid   <= 1'b1;
                    i_opcode  <= pending[0].op;
                    i_char_in <= pending[0].ch;
                    void'(pending.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got, want;
        bit   busy;
        if (i_rst_n) begin
            busy = (i_valid && o_ready) || (o_valid && i_ready);
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
            if (i_valid && o_ready) begin
                predict_lexer('{i_opcode, i_char_in});
            end
            if (o_valid && i_ready) begin
                got = '{o_token, o_field, o_char_out, o_restart, o_closing,
                        o_self_closing, o_comment, o_error_code, o_last};
                if (expected_tokens.size() == 0) begin
                    report($sformatf("unexpected result %h", got));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.token !== want.token)
                        report($sformatf("token %0d want %0d", got.token, want.token));
                    if (got.field !== want.field)
                        report($sformatf("field %0d want %0d", got.field, want.field));
                    if (got.char_out !== want.char_out)
                        report($sformatf("char %h want %h", got.char_out, want.char_out));
                    if (got.restart !== want.restart) report("restart differs");
                    if (got.closing !== want.closing) report("closing differs");
                    if (got.self_closing !== want.self_closing) report("self_closing differs");
                    if (got.comment !== want.comment) report("comment differs");
                    if (got.error_code !== want.error_code)
                        report($sformatf("error_code %0d want %0d",
                                         got.error_code, want.error_code));
                    if (got.last !== want.last) report("last differs");
                end
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic put_c(input logic [7:0] c);
        pending.push_back('{OP_CHAR, c});
    endtask

    task automatic put_s(input string s);
        foreach (s[i]) put_c(s[i]);
    endtask

    function automatic string pick_name();
        string s, al;
        int n;
        al = "abcdefghijklmnopqrstuvwxyzQZ09_:";
        s = "";
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) s = {s, string'(al[$urandom_range(al.len() - 1)])};
        return s;
    endfunction

    function automatic string pick_entity();
        case ($urandom_range(9))
            0: return "&lt;";
            1: return "&gt;";
            2: return "&amp;";
            3: return "&quot;";
            4: return $sformatf("&#%0d;", $urandom_range(300));
            5: return $sformatf("&#x%h;", $urandom_range(255));
            6: return "&#0;";
            7: return "&zz;";
            8: return "&#99999999999;";
            default: return "&l t";
        endcase
    endfunction

    task automatic gen_tag();
        int na;
        string v, ws;
        ws = " \t\r\n";
        pending.push_back('{OP_BEGIN, 8'($urandom)});
        case ($urandom_range(9))
            0: put_s({"!--", pick_name(), " -x-->"});
            1: put_s({"/", pick_name(), ">"});
            2: put_s({"?", pick_name(), " v='1'?>"});
            default: begin
                put_s(pick_name());
                na = $urandom_range(0, 3);
                for (int a = 0; a < na; a++) begin
                    put_c(ws[$urandom_range(3)]);
                    put_s(pick_name());
                    if ($urandom_range(3) == 0) put_c(" ");
                    put_c("=");
                    v = "";
                    for (int k = $urandom_range(0, 3); k > 0; k--)
                        v = {v, ($urandom_range(2) == 0) ? pick_entity() : pick_name()};
                    case ($urandom_range(2))
                        0: put_s({"\"", v, "'\""});
                        1: put_s({"'", v, "\"'"});
                        default: put_s({pick_name(), pick_entity()});
                    endcase
                end
                case ($urandom_range(5))
                    0: put_s("/>");
                    1: pending.push_back('{OP_EOS, 8'($urandom)});
                    2: put_c(8'($urandom));
                    default: put_c(">");
                endcase
            end
        endcase
        if ($urandom_range(7) == 0) pending.push_back('{2'($urandom), 8'($urandom)});
    endtask

    initial begin
        lx_state = S_IDLE;
        lx_cl = 0; lx_sc = 1; lx_cm = 0; lx_qterm = 0;
        ent_reset();
        // directed: idle chars, opcode 3, self-closing, comment, errors
        put_c("a");
        pending.push_back('{2'd3, 8'hFF});
        pending.push_back('{OP_EOS, 8'h00});
        pending.push_back('{OP_BEGIN, 8'h00});
        put_s("a b=\"&#0;&lt\"/>");
        pending.push_back('{OP_BEGIN, 8'hFF});
        put_s("!--x-->");
        pending.push_back('{OP_BEGIN, 8'h00});
        put_s("x=&#xff;");
        pending.push_back('{OP_EOS, 8'h00});
        pending.push_back('{OP_BEGIN, 8'h00});
        put_c(8'hFF); put_c("=");
        put_c(8'h00);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        running = 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 56; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 56; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            repeat (12) gen_tag();
            while (pending.size() > 0 || i_valid) @(posedge i_clk);
        end
        while (expected_tokens.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
